FILE: rtl/core/hmf_pkg.sv
package hmf_pkg;

    // Action codes carried in the request.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_FETCH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Fixed field widths of the request and result.
    localparam int SAMPLE_W = 9;
    localparam int OCC_W    = 16;

    typedef struct packed {
        logic [1:0]          action;
        logic [SAMPLE_W-1:0] sample_value;
    } request_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dominant_value;
        logic [OCC_W-1:0]    occurrences;
        logic                none_left;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_accept;
        logic clear_start;
        logic sweep;
        logic quick_miss;
        logic scan_load;
        logic scan_run;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic fetch_empty;
        logic scan_hit;
        logic scan_miss;
    } status_t;

endpackage

FILE: rtl/core/hmf_ctrl.sv
module hmf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  hmf_pkg::status_t   status,
    output hmf_pkg::cmd_t      cmd,
    output logic               busy
);

    hmf_pkg::state_t state_reg;
    hmf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            hmf_pkg::ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = hmf_pkg::ST_IDLE;
                end
            end
            hmf_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (action == hmf_pkg::ACT_ADD)
                    begin
                        cmd.add_accept = 1'b1;
                    end
                    else if (action == hmf_pkg::ACT_FETCH)
                    begin
                        state_next = hmf_pkg::ST_CHECK;
                    end
                    else if (action == hmf_pkg::ACT_CLEAR)
                    begin
                        cmd.clear_start = 1'b1;
                        state_next      = hmf_pkg::ST_CLEAR;
                    end
                end
            end
            hmf_pkg::ST_CHECK:
            begin
                if (status.fetch_empty)
                begin
                    cmd.quick_miss = 1'b1;
                    state_next     = hmf_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.scan_load = 1'b1;
                    state_next    = hmf_pkg::ST_SCAN;
                end
            end
            hmf_pkg::ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_hit || status.scan_miss)
                begin
                    state_next = hmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hmf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/hmf_datapath.sv
module hmf_datapath #(
    parameter int NUM_BINS   = 512,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hmf_pkg::request_t  request,
    input  hmf_pkg::cmd_t      cmd,
    output hmf_pkg::status_t   status,
    output hmf_pkg::result_t   result,
    output logic               result_valid
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [AW-1:0] LAST_BIN  = AW'(NUM_BINS - 1);
    localparam logic [AW:0]   BIN_END   = (AW+1)'(NUM_BINS);

    logic [CW-1:0] mem [NUM_BINS];

    logic [CW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] wr_data;

    logic [CW-1:0] max_reg,      max_next;
    logic [AW:0]   cursor_reg,   cursor_next;
    logic [AW-1:0] sweep_reg,    sweep_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_addr_reg,  s1_addr_next;
    logic          byp_valid_reg;
    logic [AW-1:0] byp_addr_reg;
    logic [CW-1:0] byp_data_reg;
    logic [AW:0]   scan_reg,     scan_next;
    logic          sv_valid_reg, sv_valid_next;
    logic [AW-1:0] sv_addr_reg,  sv_addr_next;
    hmf_pkg::result_t result_reg, result_next;
    logic          strobe_reg,   strobe_next;

    logic          in_range;
    logic [CW-1:0] add_base;
    logic [CW-1:0] add_inc;
    logic          issue;
    logic          scan_hit;
    logic          scan_miss;

    assign in_range = 32'(request.sample_value) < 32'(NUM_BINS);
    assign issue    = cmd.scan_run && (scan_reg < BIN_END);

    // The read of an add that directly follows another add sees the old word.
    assign add_base = (byp_valid_reg && (byp_addr_reg == s1_addr_reg)) ?
                      byp_data_reg : rd_data_reg;
    assign add_inc  = (add_base == COUNT_MAX) ? add_base : add_base + 1'b1;

    assign scan_hit  = sv_valid_reg && (rd_data_reg == max_reg);
    assign scan_miss = sv_valid_reg && !scan_hit && (sv_addr_reg == LAST_BIN);

    assign rd_addr = cmd.scan_run ? scan_reg[AW-1:0] : AW'(request.sample_value);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = add_inc;
        if (cmd.sweep)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = '0;
        end
        else if (s1_valid_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        max_next      = max_reg;
        cursor_next   = cursor_reg;
        sweep_next    = sweep_reg;
        s1_valid_next = cmd.add_accept && in_range;
        s1_addr_next  = AW'(request.sample_value);
        scan_next     = scan_reg;
        sv_valid_next = issue;
        sv_addr_next  = scan_reg[AW-1:0];
        result_next   = result_reg;
        strobe_next   = 1'b0;

        if (s1_valid_reg && (add_inc > max_reg))
        begin
            max_next = add_inc;
        end
        if (cmd.sweep)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
        if (cmd.clear_start)
        begin
            max_next    = '0;
            cursor_next = '0;
            sweep_next  = '0;
        end
        if (cmd.scan_load)
        begin
            scan_next = cursor_reg;
        end
        if (issue)
        begin
            scan_next = scan_reg + 1'b1;
        end
        if (cmd.quick_miss || (cmd.scan_run && scan_miss))
        begin
            strobe_next                = 1'b1;
            result_next.dominant_value = '0;
            result_next.occurrences    = hmf_pkg::OCC_W'(max_reg);
            result_next.none_left      = 1'b1;
            cursor_next                = '0;
        end
        else if (cmd.scan_run && scan_hit)
        begin
            strobe_next                = 1'b1;
            result_next.dominant_value = hmf_pkg::SAMPLE_W'(sv_addr_reg);
            result_next.occurrences    = hmf_pkg::OCC_W'(max_reg);
            result_next.none_left      = 1'b0;
            cursor_next                = {1'b0, sv_addr_reg} + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            cursor_reg    <= '0;
            sweep_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            sv_valid_reg  <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            max_reg       <= max_next;
            cursor_reg    <= cursor_next;
            sweep_reg     <= sweep_next;
            s1_valid_reg  <= s1_valid_next;
            byp_valid_reg <= s1_valid_reg;
            sv_valid_reg  <= sv_valid_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        byp_addr_reg <= s1_addr_reg;
        byp_data_reg <= add_inc;
        scan_reg     <= scan_next;
        sv_addr_reg  <= sv_addr_next;
        result_reg   <= result_next;
    end

    assign status.sweep_last  = (sweep_reg == LAST_BIN);
    assign status.fetch_empty = (max_reg == '0) || (cursor_reg >= BIN_END);
    assign status.scan_hit    = scan_hit;
    assign status.scan_miss   = scan_miss;

    assign result       = result_reg;
    assign result_valid = strobe_reg;

endmodule

FILE: rtl/core/histogram_mode_finder_unit.sv
// Add requests are accepted while idle and may follow back to back; the bin update lands in the next cycle.
// A fetch answers straight from the check when the set is empty or the scan is spent; otherwise it
// scans up from the cursor to the first bin that matches the maximum, or to the last bin, reading one
// bin per cycle through the single memory read port. Busy falls in the cycle that holds the result.
// A clear request keeps busy high while the bins are zeroed one entry a cycle,
// and reset starts the same pass. A result lasts one cycle on result_valid; it cannot be stalled.
module histogram_mode_finder_unit #(
    parameter int NUM_BINS   = 512,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hmf_pkg::request_t  request,
    output hmf_pkg::result_t   result,
    output logic               result_valid
);

    // The controller sequences the clearing pass, the fetch check and the
    // bin scan. The datapath holds the bin memory, the running maximum,
    // the fetch cursor and the one-deep add pipeline with its bypass.
    hmf_pkg::cmd_t    cmd;
    hmf_pkg::status_t status;

    hmf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Each accepted add reads its bin, and in the next cycle writes the
    // saturated increment back and raises the maximum when it is exceeded.
    // A fetch scans bins upward from the cursor, one read per cycle, and
    // stops at the first bin that matches the maximum or at the last bin.
    hmf_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

FILE: bench/histogram_mode_finder_unit_test.sv
module histogram_mode_finder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The block has 512 bins of 16-bit counters. Action code 3 has no meaning
    // and must be swallowed without a result or any change of state.
    localparam int          NUM_BINS    = 512;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int          RANDOM_REQS = 440;
    // The tail wait after the last result covers one full clear or fetch scan.
    localparam int          TAIL_CYCLES = 600;
    // Even if every request took a full scan or clear, the run would use
    // well under a third of this budget.
    localparam int          CYCLE_LIMIT = 1_200_000;

    // One row of the directed script. A row can repeat its request, which is
    // how a bin is driven to a clear lead. Rows that carry a typed-in result
    // are checked against that value; the others are checked against the
    // predictor.
    typedef struct packed {
        logic [1:0]       act;
        logic [8:0]       val;
        logic [16:0]      reps;
        logic             typed;
        hmf_pkg::result_t want;
    } script_row_t;

    localparam int SCRIPT_LEN = 23;
    localparam script_row_t DIRECTED_SCRIPT [SCRIPT_LEN] = '{
        // Fetch on an empty set right after the reset clearing pass.
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd0,   16'd0,  1'b1}},
        // The unused code must leave the empty histogram alone.
        '{ACT_UNUSED,         9'd511, 17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd0,   16'd0,  1'b1}},
        // Three single samples at the bottom, the top and the middle.
        '{hmf_pkg::ACT_ADD,   9'd0,   17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_ADD,   9'd511, 17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_ADD,   9'd255, 17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd0,   16'd1,  1'b0}},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd255, 16'd1,  1'b0}},
        // An add between fetches raises the maximum while the cursor sits
        // past the new leader, so the scan runs out and rewinds.
        '{hmf_pkg::ACT_ADD,   9'd255, 17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd0,   16'd2,  1'b1}},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd255, 16'd2,  1'b0}},
        '{hmf_pkg::ACT_CLEAR, 9'd0,   17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd0,   16'd0,  1'b1}},
        // A long run of adds makes the top bin the sole leader.
        '{hmf_pkg::ACT_ADD,   9'd511, 17'd40, 1'b0, '0},
        '{hmf_pkg::ACT_ADD,   9'd0,   17'd3,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd511, 16'd40, 1'b0}},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b1, '{9'd0,   16'd40, 1'b1}},
        '{ACT_UNUSED,         9'h155, 17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_ADD,   9'h0AA, 17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_CLEAR, 9'd0,   17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_ADD,   9'd256, 17'd2,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b0, '0},
        '{hmf_pkg::ACT_FETCH, 9'd0,   17'd1,  1'b0, '0}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    hmf_pkg::request_t request;
    hmf_pkg::result_t  result;
    logic              result_valid;

    histogram_mode_finder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

    // Shadow copy of the histogram, its running maximum and the fetch cursor.
    logic [15:0] bin_tally [NUM_BINS];
    logic [15:0] peak_count;
    int unsigned scan_pos;

    // Results still owed by the block, oldest first.
    hmf_pkg::result_t pending_modes [$];

    int unsigned mismatches;
    int unsigned cycle_count;
    bit          idle_on;
    bit          last_done;
    int unsigned n_adds;
    int unsigned n_fetches;
    int unsigned n_hits;
    int unsigned n_clears;
    int unsigned n_ignored;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one accepted request to the shadow histogram. A fetch walks up
    // from the cursor for the first bin that holds the current maximum.
    function automatic void fold_request(input hmf_pkg::request_t req, output bit yields,
                                         output hmf_pkg::result_t res);
        logic [15:0] cnt;
        int unsigned hit;
        bit          found;
        yields = 1'b0;
        res    = '0;
        found  = 1'b0;
        hit    = 0;
        case (req.action)
            hmf_pkg::ACT_ADD:
            begin
                cnt = bin_tally[req.sample_value];
                if (cnt != COUNT_MAX)
                    cnt = cnt + 16'd1;
                bin_tally[req.sample_value] = cnt;
                if (cnt > peak_count)
                    peak_count = cnt;
            end
            hmf_pkg::ACT_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                peak_count = '0;
                scan_pos   = 0;
            end
            hmf_pkg::ACT_FETCH:
            begin
                if (peak_count != 0)
                begin
                    for (int i = scan_pos; i < NUM_BINS; i++)
                    begin
                        if (!found && bin_tally[i] == peak_count)
                        begin
                            found = 1'b1;
                            hit   = i;
                        end
                    end
                end
                yields          = 1'b1;
                res.occurrences = peak_count;
                if (found)
                begin
                    res.dominant_value = hit[8:0];
                    res.none_left      = 1'b0;
                    scan_pos           = hit + 1;
                end
                else
                begin
                    res.dominant_value = '0;
                    res.none_left      = 1'b1;
                    scan_pos           = 0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Present one request from the falling edge on and hold it until a rising
    // edge sees busy low. Start stays high into the next request unless an
    // idle gap is drawn, so it is written at most once per falling edge.
    task automatic issue(input logic [1:0] act, input logic [8:0] val,
                         input bit typed, input hmf_pkg::result_t want);
        hmf_pkg::request_t req;
        hmf_pkg::result_t  got;
        bit                yields;
        if (idle_on && $urandom_range(99) < 14)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req.action       = act;
        req.sample_value = val;
        start            = 1'b1;
        request          = req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fold_request(req, yields, got);
        if (yields)
        begin
            pending_modes.push_back(typed ? want : got);
            last_done = got.none_left;
            n_fetches++;
            if (!got.none_left)
                n_hits++;
        end
        case (act)
            hmf_pkg::ACT_ADD:   n_adds++;
            hmf_pkg::ACT_CLEAR: n_clears++;
            hmf_pkg::ACT_FETCH:
            begin
            end
            default:            n_ignored++;
        endcase
        @(negedge clk);
    endtask

    // Random episodes: an optional clear, a burst of adds drawn mostly from a
    // small pool of values so that ties are common, then a walk of fetches
    // through the dominant values. Stray adds, unused codes and walks cut
    // short stir the cursor in the middle of a walk.
    task automatic run_random();
        logic [8:0]  pool [8];
        int unsigned done_reqs;
        int unsigned pool_size;
        int unsigned burst;
        int unsigned steps;
        logic [8:0]  pick;
        done_reqs = 0;
        while (done_reqs < RANDOM_REQS)
        begin
            // A quiet stretch in the middle of the run with no idle gaps.
            idle_on = !(done_reqs >= 150 && done_reqs < 300);
            if ($urandom_range(3) == 0)
            begin
                issue(hmf_pkg::ACT_CLEAR, 9'($urandom_range(0, 511)), 1'b0, '0);
                done_reqs++;
            end
            pool_size = $urandom_range(1, 6);
            for (int i = 0; i < pool_size; i++)
                pool[i] = 9'($urandom_range(0, 511));
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(9) == 0)
                    pick = 9'($urandom_range(0, 511));
                else
                    pick = pool[$urandom_range(0, pool_size - 1)];
                issue(hmf_pkg::ACT_ADD, pick, 1'b0, '0);
                done_reqs++;
            end
            steps     = 0;
            last_done = 1'b0;
            while (!last_done && steps < 10)
            begin
                if ($urandom_range(7) == 0)
                begin
                    issue(hmf_pkg::ACT_ADD, pool[$urandom_range(0, pool_size - 1)],
                          1'b0, '0);
                    done_reqs++;
                end
                if ($urandom_range(15) == 0)
                    issue(ACT_UNUSED, 9'($urandom_range(0, 511)), 1'b0, '0);
                issue(hmf_pkg::ACT_FETCH, 9'($urandom_range(0, 511)), 1'b0, '0);
                done_reqs++;
                steps++;
                if ($urandom_range(5) == 0)
                    break;
            end
        end
    endtask

    // Results are sampled at the rising edge and matched against the oldest
    // outstanding expectation, field by field.
    always @(posedge clk)
    begin : check_result
        hmf_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_modes.size() == 0)
            begin
                $error("unexpected result: dominant_value %0d occurrences %0d none_left %0b",
                       result.dominant_value, result.occurrences, result.none_left);
                mismatches++;
            end
            else
            begin
                want = pending_modes.pop_front();
                if (result.dominant_value !== want.dominant_value)
                begin
                    $error("dominant_value: expected %0d, got %0d",
                           want.dominant_value, result.dominant_value);
                    mismatches++;
                end
                if (result.occurrences !== want.occurrences)
                begin
                    $error("occurrences: expected %0d, got %0d",
                           want.occurrences, result.occurrences);
                    mismatches++;
                end
                if (result.none_left !== want.none_left)
                begin
                    $error("none_left: expected %0b, got %0b",
                           want.none_left, result.none_left);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung block must not keep the simulation alive.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_modes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        mismatches  = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        last_done   = 1'b0;
        n_adds      = 0;
        n_fetches   = 0;
        n_hits      = 0;
        n_clears    = 0;
        n_ignored   = 0;
        peak_count  = '0;
        scan_pos    = 0;
        foreach (bin_tally[i])
            bin_tally[i] = '0;

        // Reset is released on a falling edge. The block then runs its own
        // clearing pass with busy high; the first request simply waits it out.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_SCRIPT[r])
        begin
            for (int k = 0; k < DIRECTED_SCRIPT[r].reps; k++)
                issue(DIRECTED_SCRIPT[r].act, DIRECTED_SCRIPT[r].val,
                      DIRECTED_SCRIPT[r].typed, DIRECTED_SCRIPT[r].want);
        end

        run_random();
        start = 1'b0;

        // Drain every owed result, then give a trailing clear or scan time to
        // finish so that a late stray result would still be seen.
        while (pending_modes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_modes.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_modes.size());
            mismatches++;
        end

        $display("Covered %0d adds, %0d clears, %0d unused codes,",
                 n_adds, n_clears, n_ignored);
        $display("and %0d fetches of which %0d found a dominant value; %0d mismatches.",
                 n_fetches, n_hits, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
